### sv/arrs_pkg.sv
// ----------------------------------------------------------------------------
// arrs_pkg
// Types and constants shared by the round robin ADC channel scanner.
// ----------------------------------------------------------------------------
package arrs_pkg;

  localparam int NUM_CHANNELS_DEF = 8;
  localparam int SAMPLE_BITS      = 10;
  localparam int TIMER_BITS       = 16;
  localparam int MASK_BITS        = 8;
  localparam int CHAN_OUT_BITS    = 3;
  localparam int READ_CH_BITS     = 4;
  localparam int CFG_INDEX_BITS   = 2;
  localparam int CFG_DATA_BITS    = 16;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX     = '1;
  localparam logic [TIMER_BITS-1:0] SETTLE_RESET  = TIMER_BITS'(10);
  localparam logic [TIMER_BITS-1:0] SAMPLE_RESET  = TIMER_BITS'(90);

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_MASK = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SETTLE_TICKS = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLE_TICKS = 2'd2;

  typedef enum logic {
    PH_START,
    PH_COLLECT
  } phase_t;

  typedef struct packed {
    logic                    converter_busy;
    logic [SAMPLE_BITS-1:0]  conversion_value;
    logic [READ_CH_BITS-1:0] read_channel;
  } tick_t;

  typedef struct packed {
    logic                     start_conversion;
    logic [CHAN_OUT_BITS-1:0] conversion_channel;
    logic                     sample_taken;
    logic [CHAN_OUT_BITS-1:0] active_channel;
    logic [SAMPLE_BITS-1:0]   read_value;
  } result_t;

endpackage

### sv/arrs_next_channel.sv
// ----------------------------------------------------------------------------
// arrs_next_channel
// Rotating priority pick: first enabled channel after the current one.
// ----------------------------------------------------------------------------
module arrs_next_channel
  import arrs_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic [CH_W-1:0]         current,
  input  logic [NUM_CHANNELS-1:0] enabled,
  output logic [CH_W-1:0]         next
);

  localparam logic [CH_W:0] NUM_CH_L = (CH_W+1)'(NUM_CHANNELS);

  always_comb begin
    logic [CH_W:0] sum;
    logic [CH_W:0] cand;
    // keep the current channel when no other one is enabled
    next = current;
    // walk from the farthest offset down so the nearest enabled one wins
    for (int k = NUM_CHANNELS - 1; k >= 1; k--) begin
      sum  = {1'b0, current} + (CH_W+1)'(k);
      cand = (sum >= NUM_CH_L) ? (sum - NUM_CH_L) : sum;
      if (enabled[cand[CH_W-1:0]]) begin
        next = cand[CH_W-1:0];
      end
    end
  end

endmodule

### sv/adc_round_robin_channel_scanner.sv
// ----------------------------------------------------------------------------
// adc_round_robin_channel_scanner
// Round robin scan sequencer for a multichannel converter with settle and
// sample timers and a per-channel sample store.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  tick    | tick_valid/tick_stall | tick     (tick_t)
//  result  | result_valid/stall    | result   (result_t)
//  config  | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// One tick per cycle; each accepted tick yields its result in the result
// register in the next cycle. The channel pick and timer compares settle in
// one pass. The tick side stalls only while the result register holds an
// untaken item. Reset clears state, timers, the sample store and loads register defaults.
// ----------------------------------------------------------------------------
module adc_round_robin_channel_scanner
  import arrs_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      tick_valid,
  output logic                      tick_stall,
  input  tick_t                     tick,
  output logic                      result_valid,
  input  logic                      result_stall,
  output result_t                   result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [READ_CH_BITS:0] NUM_CH_RD = (READ_CH_BITS+1)'(NUM_CHANNELS);

  logic [MASK_BITS-1:0]  channel_mask;
  logic [TIMER_BITS-1:0] settle_ticks;
  logic [TIMER_BITS-1:0] sample_ticks;

  phase_t                phase, phase_next;
  logic [CH_W-1:0]       current_channel, current_channel_next;
  logic [TIMER_BITS-1:0] settle_count, settle_count_next;
  logic [TIMER_BITS-1:0] sample_count, sample_count_next;
  logic [SAMPLE_BITS-1:0] sample_store [NUM_CHANNELS];

  logic [NUM_CHANNELS-1:0] enabled;
  logic [CH_W-1:0]         advanced;
  logic [TIMER_BITS-1:0]   settle_inc, sample_inc;
  logic                    started, taken;
  logic                    accept;
  logic                    rd_in_range;
  logic [CH_W-1:0]         rd_index;
  result_t                 result_next;

  assign accept     = tick_valid && !tick_stall;
  assign tick_stall = result_valid && result_stall;
  assign cfg_ready  = 1'b1;

  // channels beyond the mask width are never enabled
  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_en
    if (i < MASK_BITS) begin : g_mask
      assign enabled[i] = channel_mask[i];
    end else begin : g_none
      assign enabled[i] = 1'b0;
    end
  end

  arrs_next_channel #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .CH_W        (CH_W)
  ) u_next (
    .current(current_channel),
    .enabled(enabled),
    .next   (advanced)
  );

  assign settle_inc = (settle_count == TIMER_MAX) ? TIMER_MAX : settle_count + 1'b1;
  assign sample_inc = (sample_count == TIMER_MAX) ? TIMER_MAX : sample_count + 1'b1;

  // next state
  always_comb begin
    phase_next           = phase;
    current_channel_next = current_channel;
    settle_count_next    = settle_inc;
    sample_count_next    = sample_inc;
    if (channel_mask != '0) begin
      unique case (phase)
        PH_START: begin
          if (enabled[current_channel]) begin
            if (settle_inc >= settle_ticks) begin
              sample_count_next = '0;
              phase_next        = PH_COLLECT;
            end
          end else begin
            current_channel_next = advanced;
          end
        end
        PH_COLLECT: begin
          if (!tick.converter_busy && sample_inc >= sample_ticks) begin
            current_channel_next = advanced;
            phase_next           = PH_START;
            settle_count_next    = '0;
          end
        end
        default: begin
          phase_next = PH_START;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    started = 1'b0;
    taken   = 1'b0;
    if (channel_mask != '0) begin
      unique case (phase)
        PH_START:   started = enabled[current_channel] && (settle_inc >= settle_ticks);
        PH_COLLECT: taken   = !tick.converter_busy && (sample_inc >= sample_ticks);
        default:    started = 1'b0;
      endcase
    end
  end

  assign rd_in_range = {1'b0, tick.read_channel} < NUM_CH_RD;
  assign rd_index    = CH_W'(tick.read_channel);

  always_comb begin
    result_next.start_conversion   = started;
    result_next.conversion_channel = started ? CHAN_OUT_BITS'(current_channel) : '0;
    result_next.sample_taken       = taken;
    result_next.active_channel     = CHAN_OUT_BITS'(current_channel_next);
    // forward a value stored on this tick to a read of the same channel
    if (!rd_in_range) begin
      result_next.read_value = '0;
    end else if (taken && rd_index == current_channel) begin
      result_next.read_value = tick.conversion_value;
    end else begin
      result_next.read_value = sample_store[rd_index];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_mask <= '0;
      settle_ticks <= SETTLE_RESET;
      sample_ticks <= SAMPLE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CHANNEL_MASK: channel_mask <= cfg_data[MASK_BITS-1:0];
        REG_SETTLE_TICKS: settle_ticks <= TIMER_BITS'(cfg_data);
        REG_SAMPLE_TICKS: sample_ticks <= TIMER_BITS'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_START;
      current_channel <= '0;
      settle_count    <= '0;
      sample_count    <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        sample_store[i] <= '0;
      end
    end else if (accept) begin
      phase           <= phase_next;
      current_channel <= current_channel_next;
      settle_count    <= settle_count_next;
      sample_count    <= sample_count_next;
      if (taken) begin
        sample_store[current_channel] <= tick.conversion_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

endmodule
